// ----- sv/dges_pkg.sv -----
// ----------------------------------------------------------------------------
// dges_pkg
// shared types, constants and saturation helpers for the euler step block
// ----------------------------------------------------------------------------
package dges_pkg;

  localparam int QW = 32;
  localparam int UW = 31;
  localparam int DTW = 17;
  localparam int MW = 33;
  localparam int PW = 2 * MW;

  localparam logic signed [QW-1:0] COLLIDE_VY = -32'sd590;
  localparam logic [UW-1:0] INV_MASS_RST = 31'd65536;
  localparam logic signed [QW-1:0] GRAVITY_RST = -32'sd642253;
  localparam logic [UW-1:0] DRAG_RST = 31'd0;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_INV_MASS = 2'd0,
    REG_GRAVITY  = 2'd1,
    REG_DRAG     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_SUM,
    OP_MUL_SQ,
    OP_ADD_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SAVE_LEN,
    OP_SAVE_SPEED,
    OP_MUL_P,
    OP_SAVE_P,
    OP_MUL_MAG,
    OP_SAVE_MAG,
    OP_MUL_DRAG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SAVE_DRAG,
    OP_MUL_ACC,
    OP_SAVE_ACC,
    OP_MUL_DV,
    OP_ADD_VEL,
    OP_MUL_DS,
    OP_ADD_POS,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_CLR,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_SQRT_INIT,
    ST_SQRT_STEP,
    ST_SQRT_DONE,
    ST_P_MUL,
    ST_P_SAVE,
    ST_MAG_MUL,
    ST_MAG_SAVE,
    ST_DR_MUL,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DR_SAVE,
    ST_A_MUL,
    ST_A_SAVE,
    ST_DV_MUL,
    ST_V_ADD,
    ST_DS_MUL,
    ST_POS_ADD,
    ST_OUT
  } ctl_state_t;

  function automatic logic signed [QW-1:0] sat32_shr16(input logic signed [PW-1:0] p);
    logic signed [PW-17:0] s;
    s = p[PW-1:16];
    if (s[PW-17:QW-1] == '0 || s[PW-17:QW-1] == '1) begin
      return s[QW-1:0];
    end else if (s[PW-17]) begin
      return {1'b1, {(QW-1){1'b0}}};
    end else begin
      return {1'b0, {(QW-1){1'b1}}};
    end
  endfunction

  function automatic logic [UW-1:0] sat31_shr16(input logic signed [PW-1:0] p);
    if (p[PW-1:UW+16] != '0) begin
      return {UW{1'b1}};
    end else begin
      return p[UW+15:16];
    end
  endfunction

  function automatic logic signed [QW-1:0] sat32_add(input logic signed [QW-1:0] a,
                                                    input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      return s[QW-1:0];
    end
  endfunction

endpackage

// ----- sv/dges_ctrl.sv -----
// ----------------------------------------------------------------------------
// dges_ctrl
// sequencer that steps the shared multiplier, square root and divider
// ----------------------------------------------------------------------------
module dges_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_collision,
  output logic              in_ready,
  input  dges_pkg::dp_stat_t stat,
  output dges_pkg::dp_cmd_t  cmd
);
  import dges_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lane_r  <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NONE;
    cmd.lane  = lane_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op   = OP_LOAD;
          lane_nxt = '0;
          if (in_collision) begin
            state_nxt = ST_A_MUL;
          end else begin
            phase_nxt = 1'b0;
            state_nxt = ST_SQ_CLR;
          end
        end
      end
      ST_SQ_CLR: begin
        cmd.op    = OP_CLR_SUM;
        lane_nxt  = '0;
        state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        cmd.op    = OP_MUL_SQ;
        state_nxt = ST_SQ_ADD;
      end
      ST_SQ_ADD: begin
        cmd.op = OP_ADD_SQ;
        if (lane_r == 2'd2) begin
          state_nxt = ST_SQRT_INIT;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT_STEP;
      end
      ST_SQRT_STEP: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == '1) begin
          state_nxt = ST_SQRT_DONE;
        end
      end
      ST_SQRT_DONE: begin
        lane_nxt = '0;
        if (phase_r) begin
          cmd.op    = OP_SAVE_SPEED;
          state_nxt = ST_DS_MUL;
        end else begin
          cmd.op    = OP_SAVE_LEN;
          state_nxt = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        cmd.op    = OP_MUL_P;
        state_nxt = ST_P_SAVE;
      end
      ST_P_SAVE: begin
        cmd.op    = OP_SAVE_P;
        state_nxt = ST_MAG_MUL;
      end
      ST_MAG_MUL: begin
        cmd.op    = OP_MUL_MAG;
        state_nxt = ST_MAG_SAVE;
      end
      ST_MAG_SAVE: begin
        cmd.op    = OP_SAVE_MAG;
        lane_nxt  = '0;
        state_nxt = ST_DR_MUL;
      end
      ST_DR_MUL: begin
        cmd.op    = OP_MUL_DRAG;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == '1) begin
          state_nxt = ST_DR_SAVE;
        end
      end
      ST_DR_SAVE: begin
        cmd.op = OP_SAVE_DRAG;
        if (lane_r == 2'd2) begin
          lane_nxt  = '0;
          state_nxt = ST_A_MUL;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_DR_MUL;
        end
      end
      ST_A_MUL: begin
        cmd.op    = OP_MUL_ACC;
        state_nxt = ST_A_SAVE;
      end
      ST_A_SAVE: begin
        cmd.op    = OP_SAVE_ACC;
        state_nxt = ST_DV_MUL;
      end
      ST_DV_MUL: begin
        cmd.op    = OP_MUL_DV;
        state_nxt = ST_V_ADD;
      end
      ST_V_ADD: begin
        cmd.op = OP_ADD_VEL;
        if (lane_r == 2'd2) begin
          phase_nxt = 1'b1;
          state_nxt = ST_SQ_CLR;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_A_MUL;
        end
      end
      ST_DS_MUL: begin
        cmd.op    = OP_MUL_DS;
        state_nxt = ST_POS_ADD;
      end
      ST_POS_ADD: begin
        cmd.op = OP_ADD_POS;
        if (lane_r == 2'd2) begin
          state_nxt = ST_OUT;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_DS_MUL;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/dges_dpath.sv -----
// ----------------------------------------------------------------------------
// dges_dpath
// state, config registers, shared multiplier, bit-serial sqrt and divider
// ----------------------------------------------------------------------------
module dges_dpath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dges_pkg::dp_cmd_t        cmd,
  output dges_pkg::dp_stat_t       stat,
  input  logic                     cfg_valid,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [16:0]              in_time_step,
  input  logic                     in_collision,
  input  logic signed [31:0]       in_impact_x,
  input  logic signed [31:0]       in_impact_y,
  input  logic signed [31:0]       in_impact_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       out_pos_x,
  output logic signed [31:0]       out_pos_y,
  output logic signed [31:0]       out_pos_z,
  output logic signed [31:0]       out_vel_x,
  output logic signed [31:0]       out_vel_y,
  output logic signed [31:0]       out_vel_z,
  output logic [30:0]              out_speed_out
);
  import dges_pkg::*;

  logic [UW-1:0]         inv_mass_r, drag_r;
  logic signed [QW-1:0]  gravity_r;
  logic signed [QW-1:0]  pos_r [3];
  logic signed [QW-1:0]  vel_r [3];
  logic signed [QW-1:0]  force_r [3];
  logic [UW-1:0]         speed_r;
  logic [DTW-1:0]        dt_r;
  logic signed [PW-1:0]  prod_r;
  logic [63:0]           sum_r, x_r, res_r, bit_r;
  logic [QW-1:0]         len_r;
  logic [UW-1:0]         p_r, mag_r;
  logic signed [QW-1:0]  acc_r;
  logic [QW-1:0]         rem_r, num_r, quo_r;
  logic                  out_valid_r;
  logic signed [QW-1:0]  opos_r [3];
  logic signed [QW-1:0]  ovel_r [3];
  logic [UW-1:0]         ospeed_r;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [QW-1:0]  v_sel;
  logic [QW-1:0]         v_abs;
  logic [63:0]           sq_t;
  logic [QW:0]           div_r2;
  logic signed [QW:0]    drag_d;
  logic signed [QW-1:0]  drag_f;

  assign v_sel = vel_r[cmd.lane];
  assign v_abs = v_sel[QW-1] ? QW'(-v_sel) : QW'(v_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_SQ: begin
        mul_a = MW'(v_sel);
        mul_b = MW'(v_sel);
      end
      OP_MUL_P: begin
        mul_a = {2'b00, drag_r};
        mul_b = {2'b00, speed_r};
      end
      OP_MUL_MAG: begin
        mul_a = {2'b00, p_r};
        mul_b = {2'b00, speed_r};
      end
      OP_MUL_DRAG: begin
        mul_a = {1'b0, v_abs};
        mul_b = {2'b00, mag_r};
      end
      OP_MUL_ACC: begin
        mul_a = MW'(force_r[cmd.lane]);
        mul_b = {2'b00, inv_mass_r};
      end
      OP_MUL_DV: begin
        mul_a = MW'(acc_r);
        mul_b = {{(MW-DTW){1'b0}}, dt_r};
      end
      OP_MUL_DS: begin
        mul_a = MW'(v_sel);
        mul_b = {{(MW-DTW){1'b0}}, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign sq_t   = res_r + bit_r;
  assign div_r2 = {rem_r, num_r[QW-1]};
  assign drag_d = (len_r == '0) ? '0 :
                  (v_sel > 0) ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign drag_f = (cmd.lane == 2'd1) ? sat32_add(drag_d[QW-1:0], gravity_r)
                                     : drag_d[QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r <= INV_MASS_RST;
      gravity_r  <= GRAVITY_RST;
      drag_r     <= DRAG_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_INV_MASS: inv_mass_r <= cfg_data[UW-1:0];
        REG_GRAVITY:  gravity_r  <= $signed(cfg_data);
        REG_DRAG:     drag_r     <= cfg_data[UW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_OUT) || (out_valid_r && !out_ready);
      case (cmd.op)
        OP_LOAD: begin
          dt_r <= in_time_step;
          if (in_collision) begin
            vel_r[0]   <= '0;
            vel_r[1]   <= COLLIDE_VY;
            vel_r[2]   <= '0;
            force_r[0] <= in_impact_x;
            force_r[1] <= in_impact_y;
            force_r[2] <= in_impact_z;
          end
        end
        OP_CLR_SUM:    sum_r <= '0;
        OP_ADD_SQ:     sum_r <= sum_r + prod_r[63:0];
        OP_SQRT_INIT: begin
          x_r   <= sum_r;
          res_r <= '0;
          bit_r <= SQRT_BIT0;
        end
        OP_SQRT_STEP: begin
          if (x_r >= sq_t) begin
            x_r   <= x_r - sq_t;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        OP_SAVE_LEN:   len_r <= res_r[QW-1:0];
        OP_SAVE_SPEED: speed_r <= (res_r[63:UW] != '0) ? {UW{1'b1}} : res_r[UW-1:0];
        OP_SAVE_P:     p_r <= sat31_shr16(prod_r);
        OP_SAVE_MAG:   mag_r <= sat31_shr16(prod_r);
        OP_DIV_INIT: begin
          rem_r <= prod_r[63:32];
          num_r <= prod_r[31:0];
          quo_r <= '0;
        end
        OP_DIV_STEP: begin
          num_r <= num_r << 1;
          if (div_r2 >= {1'b0, len_r}) begin
            rem_r <= QW'(div_r2 - {1'b0, len_r});
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= div_r2[QW-1:0];
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
        end
        OP_SAVE_DRAG:  force_r[cmd.lane] <= drag_f;
        OP_SAVE_ACC:   acc_r <= sat32_shr16(prod_r);
        OP_ADD_VEL:    vel_r[cmd.lane] <= sat32_add(v_sel, sat32_shr16(prod_r));
        OP_ADD_POS:    pos_r[cmd.lane] <= sat32_add(pos_r[cmd.lane], sat32_shr16(prod_r));
        OP_OUT: begin
          for (int i = 0; i < 3; i++) begin
            opos_r[i] <= pos_r[i];
            ovel_r[i] <= vel_r[i];
          end
          ospeed_r <= speed_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL_SQ, OP_MUL_P, OP_MUL_MAG, OP_MUL_DRAG,
      OP_MUL_ACC, OP_MUL_DV, OP_MUL_DS: prod_r <= mul_p;
      default: begin
      end
    endcase
  end

  assign stat.out_busy = out_valid_r & ~out_ready;
  assign out_valid     = out_valid_r;
  assign out_pos_x     = opos_r[0];
  assign out_pos_y     = opos_r[1];
  assign out_pos_z     = opos_r[2];
  assign out_vel_x     = ovel_r[0];
  assign out_vel_y     = ovel_r[1];
  assign out_vel_z     = ovel_r[2];
  assign out_speed_out = ospeed_r;

endmodule

// ----- sv/drag_gravity_euler_step.sv -----
// ----------------------------------------------------------------------------
// drag_gravity_euler_step
// one explicit euler tick of a point body under gravity and quadratic drag
//
// input channel (in_valid/in_ready): one request per tick with time step,
// collision flag and impact force. result channel (out_valid/out_ready):
// new position, velocity and speed, q16.16 saturated.
// config channel (cfg_valid/cfg_ready): always ready, index 0 inverse
// mass, 1 gravity force, 2 drag coefficient; unknown indexes are dropped.
// work per tick: two 32-step square roots and three 32-step divides in free
// flight, around one shared 33x33 multiplier, and a single square root on a
// collision tick. one request at a time; in_ready is high only when idle.
// results sit in an output register, so the next request is taken while a
// result waits; a finished tick holds until that register is free.
// reset: synchronous, clears position, velocity and speed, loads the config
// defaults and drops any pending result.
// ----------------------------------------------------------------------------
module drag_gravity_euler_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [16:0]        in_time_step,
  input  logic               in_collision,
  input  logic signed [31:0] in_impact_x,
  input  logic signed [31:0] in_impact_y,
  input  logic signed [31:0] in_impact_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic [30:0]        out_speed_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dges_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dges_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_collision (in_collision),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  dges_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_time_step  (in_time_step),
    .in_collision  (in_collision),
    .in_impact_x   (in_impact_x),
    .in_impact_y   (in_impact_y),
    .in_impact_z   (in_impact_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_vel_x     (out_vel_x),
    .out_vel_y     (out_vel_y),
    .out_vel_z     (out_vel_z),
    .out_speed_out (out_speed_out)
  );

endmodule

// ----- sv/dges_checker.sv -----
// ----------------------------------------------------------------------------
// dges_checker
// port-level checks on the euler step block, bound to the top level
// ----------------------------------------------------------------------------
module dges_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [30:0] out_speed_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_speed_out))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind drag_gravity_euler_step dges_checker u_dges_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_speed_out (out_speed_out)
);
